@@ hw/rtl/mtwd_pkg.sv @@
// Package with shared types and codes for the multi-task watchdog monitor.
`default_nettype none

package mtwd_pkg;

  // Command codes
  localparam logic [2:0] CMD_INIT     = 3'd0;
  localparam logic [2:0] CMD_REGISTER = 3'd1;
  localparam logic [2:0] CMD_ENABLE   = 3'd2;
  localparam logic [2:0] CMD_DISABLE  = 3'd3;
  localparam logic [2:0] CMD_PERIOD   = 3'd4;
  localparam logic [2:0] CMD_FEED     = 3'd5;
  localparam logic [2:0] CMD_CHECK    = 3'd6;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_STATE = 3'd1;
  localparam logic [2:0] ST_BAD_PARAM = 3'd2;
  localparam logic [2:0] ST_BUSY      = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // Input transaction
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  task_id;
    logic [31:0] period;
    logic [31:0] now_tick;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  assigned_id;
    logic [15:0] expired_mask;
  } out_t;

  // Table write operations broadcast to the cells
  typedef enum logic [2:0] {
    WR_NONE     = 3'd0,
    WR_REGISTER = 3'd1,
    WR_ENABLE   = 3'd2,
    WR_DISABLE  = 3'd3,
    WR_PERIOD   = 3'd4,
    WR_FEED     = 3'd5
  } wr_op_t;

  // Broadcast write bus
  typedef struct packed {
    wr_op_t      op;
    logic [7:0]  id;
    logic [31:0] period;
    logic [31:0] now;
  } wr_t;

  // Check token passed cell to cell
  typedef struct packed {
    logic        valid;
    logic [31:0] now;
    logic        hit;
    logic [15:0] mask;
  } tok_t;

endpackage

`default_nettype wire

@@ hw/rtl/mtwd_cell.sv @@
// One task slot of the watchdog chain: holds its entry and checks the passing token.
`default_nettype none

module mtwd_cell
  import mtwd_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire wr_t  wr,
  input  wire tok_t tok_i,
  output tok_t      tok_o
);

  localparam logic [7:0]  MY_ID = 8'(IDX);
  localparam logic [15:0] BIT_M = (IDX < 16) ? (16'd1 << IDX) : 16'd0;

  logic [31:0] period_r;
  logic [31:0] last_r;
  logic        en_r;
  logic        used_r;
  tok_t        tok_r;
  tok_t        tok_nxt;
  logic [31:0] elapsed;
  logic        expired;
  logic        sel;

  assign sel = (wr.id == MY_ID);

  // Entry storage; period and last-feed have no reset
  always_ff @(posedge clk) begin
    if (sel) begin
      unique case (wr.op)
        WR_REGISTER: begin
          period_r <= wr.period;
          last_r   <= wr.now;
        end
        WR_ENABLE: last_r   <= wr.now;
        WR_PERIOD: period_r <= wr.period;
        WR_FEED:   last_r   <= wr.now;
        default: ;
      endcase
    end
  end

  // Flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      used_r <= 1'b0;
    end else if (sel) begin
      unique case (wr.op)
        WR_REGISTER: begin
          en_r   <= 1'b0;
          used_r <= 1'b1;
        end
        WR_ENABLE:  en_r <= 1'b1;
        WR_DISABLE: en_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // Timeout test on the token passing through, modular elapsed time
  always_comb begin
    elapsed = tok_i.now - last_r;
    expired = tok_i.valid & used_r & en_r & (elapsed > period_r);
    tok_nxt = tok_i;
    tok_nxt.hit  = tok_i.hit | expired;
    tok_nxt.mask = tok_i.mask | (expired ? BIT_M : 16'd0);
  end

  // Token stage to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.now  <= tok_nxt.now;
    tok_r.hit  <= tok_nxt.hit;
    tok_r.mask <= tok_nxt.mask;
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

@@ hw/rtl/multi_task_watchdog_monitor_unit.sv @@
// Top level of the multi-task watchdog monitor: command decode and the chain of task cells.
//
//  channel  | ports                          | transfer
//  ---------+--------------------------------+----------------------------------
//  command  | start, busy, in_data (in_t)    | taken when start && !busy
//  result   | out_valid, out_data (out_t)    | one cycle per result, no stall
//
// A command other than a valid check gives its result in the cycle after it is taken.
// A check sends a token down the row of MAX_TASKS cells, one cell per cycle; its result
// passes each cell's token register, then the result register; busy falls as it appears.
// rst_n is synchronous, active low; it clears the init flag, task count and enables.
// The result channel cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module multi_task_watchdog_monitor_unit
  import mtwd_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int CW = $clog2(MAX_TASKS + 1);

  logic          init_r, init_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          busy_r, busy_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;
  wr_t           wr;
  tok_t          tok [MAX_TASKS+1];
  logic          accept;
  logic          walk;
  logic          id_bad;
  logic [7:0]    count_id;

  assign accept   = start & ~busy_r;
  assign id_bad   = (in_data.task_id >= 8'(MAX_TASKS));
  assign count_id = 8'(count_r);

  // Command decode
  always_comb begin
    init_nxt      = init_r;
    count_nxt     = count_r;
    walk          = 1'b0;
    wr.op         = WR_NONE;
    wr.id         = in_data.task_id;
    wr.period     = in_data.period;
    wr.now        = in_data.now_tick;
    out_data_nxt  = '0;
    out_valid_nxt = 1'b0;
    if (accept) begin
      out_valid_nxt = 1'b1;
      unique case (in_data.cmd)
        CMD_INIT: begin
          if (init_r) out_data_nxt.status = ST_BAD_STATE;
          else        init_nxt = 1'b1;
        end
        CMD_REGISTER: begin
          priority if (!init_r) begin
            out_data_nxt.status = ST_BAD_STATE;
          end else if (count_r == CW'(MAX_TASKS)) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            wr.op     = WR_REGISTER;
            wr.id     = count_id;
            count_nxt = count_r + CW'(1);
            out_data_nxt.assigned_id = count_id[3:0];
          end
        end
        CMD_ENABLE, CMD_DISABLE, CMD_PERIOD, CMD_FEED: begin
          priority if (id_bad) begin
            out_data_nxt.status = ST_BAD_PARAM;
          end else if (!init_r) begin
            out_data_nxt.status = ST_BAD_STATE;
          end else begin
            unique case (in_data.cmd)
              CMD_ENABLE:  wr.op = WR_ENABLE;
              CMD_DISABLE: wr.op = WR_DISABLE;
              CMD_PERIOD:  wr.op = WR_PERIOD;
              default:     wr.op = WR_FEED;
            endcase
          end
        end
        CMD_CHECK: begin
          if (!init_r) begin
            out_data_nxt.status = ST_BAD_STATE;
          end else begin
            walk          = 1'b1;
            out_valid_nxt = 1'b0;
          end
        end
        default: out_data_nxt.status = ST_BAD_PARAM;
      endcase
    end else if (tok[MAX_TASKS].valid) begin
      // Check token left the last cell
      out_valid_nxt             = 1'b1;
      out_data_nxt.status       = tok[MAX_TASKS].hit ? ST_BUSY : ST_OK;
      out_data_nxt.expired_mask = tok[MAX_TASKS].mask;
    end
  end

  // Busy from a check start until its token leaves the chain
  always_comb begin
    busy_nxt = busy_r;
    if (walk) busy_nxt = 1'b1;
    else if (tok[MAX_TASKS].valid) busy_nxt = 1'b0;
  end

  // Token entering the first cell
  always_comb begin
    tok[0].valid = walk;
    tok[0].now   = in_data.now_tick;
    tok[0].hit   = 1'b0;
    tok[0].mask  = 16'd0;
  end

  // Row of task cells
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    mtwd_cell #(
      .IDX(i)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .wr   (wr),
      .tok_i(tok[i]),
      .tok_o(tok[i+1])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= 1'b0;
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      init_r      <= init_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ verif/tb_multi_task_watchdog_monitor_unit.sv @@
// Testbench for the multi-task watchdog monitor: directed and random commands against a predictor.
`default_nettype none

module tb_multi_task_watchdog_monitor_unit;
  import mtwd_pkg::*;

  localparam int          TASK_SLOTS  = 16;
  localparam int          DRAIN_WAIT  = 2 * TASK_SLOTS + 8;
  localparam logic [2:0]  CMD_UNUSED  = 3'd7;
  localparam logic [31:0] TICK_ALL    = 32'hFFFF_FFFF;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  multi_task_watchdog_monitor_unit #(.MAX_TASKS(TASK_SLOTS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Shadow copy of the watchdog table
  logic        shadow_init;
  int          shadow_count;
  logic [31:0] shadow_period [TASK_SLOTS];
  logic [31:0] shadow_fed_at [TASK_SLOTS];
  logic        shadow_armed  [TASK_SLOTS];

  in_t  pending_cmds[$];
  out_t expected_results[$];

  int   idle_pct = 0;
  logic took = 1'b0;
  int   errors = 0;
  int   n_results = 0;
  int   n_checks = 0;
  int   n_timeouts = 0;
  int   n_registers = 0;
  int   n_full = 0;

  // Apply one command to the shadow table and return its result
  function automatic out_t predict_watchdog(in_t item);
    out_t        res;
    logic [31:0] elapsed;
    res = '0;
    res.status = ST_OK;
    case (item.cmd)
      CMD_INIT: begin
        if (shadow_init) res.status = ST_BAD_STATE;
        else shadow_init = 1'b1;
      end
      CMD_REGISTER: begin
        if (!shadow_init) begin
          res.status = ST_BAD_STATE;
        end else if (shadow_count >= TASK_SLOTS) begin
          res.status = ST_FULL;
        end else begin
          shadow_period[shadow_count] = item.period;
          shadow_fed_at[shadow_count] = item.now_tick;
          shadow_armed[shadow_count]  = 1'b0;
          res.assigned_id = 4'(shadow_count);
          shadow_count++;
        end
      end
      CMD_ENABLE, CMD_DISABLE, CMD_PERIOD, CMD_FEED: begin
        // bad id wins over the init test
        if (item.task_id >= TASK_SLOTS) begin
          res.status = ST_BAD_PARAM;
        end else if (!shadow_init) begin
          res.status = ST_BAD_STATE;
        end else begin
          case (item.cmd)
            CMD_ENABLE: begin
              shadow_armed[item.task_id]  = 1'b1;
              shadow_fed_at[item.task_id] = item.now_tick;
            end
            CMD_DISABLE: shadow_armed[item.task_id]  = 1'b0;
            CMD_PERIOD:  shadow_period[item.task_id] = item.period;
            default:     shadow_fed_at[item.task_id] = item.now_tick;
          endcase
        end
      end
      CMD_CHECK: begin
        if (!shadow_init) begin
          res.status = ST_BAD_STATE;
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            // modular elapsed time
            elapsed = item.now_tick - shadow_fed_at[i];
            if (shadow_armed[i] && elapsed > shadow_period[i]) begin
              res.status = ST_BUSY;
              res.expired_mask[i] = 1'b1;
            end
          end
        end
      end
      default: res.status = ST_BAD_PARAM;
    endcase
    return res;
  endfunction

  function automatic in_t make_cmd(logic [2:0] cmd, logic [7:0] id, logic [31:0] period,
                                   logic [31:0] now);
    in_t item;
    item.cmd      = cmd;
    item.task_id  = id;
    item.period   = period;
    item.now_tick = now;
    return item;
  endfunction

  // Timeout periods: mostly short so tasks actually expire
  function automatic logic [31:0] pick_period();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return TICK_ALL;
      2: return $urandom;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: presents queued commands, holds each until taken
  always @(negedge clk) begin : driver
    logic nxt_start;
    in_t  nxt_data;
    nxt_start = start;
    nxt_data  = in_data;
    if (start && took) nxt_start = 1'b0;
    if (rst_n && !nxt_start && pending_cmds.size() > 0 &&
        $urandom_range(0, 99) >= idle_pct) begin
      nxt_start = 1'b1;
      nxt_data  = pending_cmds.pop_front();
    end
    start   <= nxt_start;
    in_data <= nxt_data;
  end

  // Monitor: checks results, then predicts for the transaction taken at this edge
  always @(posedge clk) begin : monitor
    out_t exp_res;
    if (out_valid) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d id %0d mask %h",
               out_data.status, out_data.assigned_id, out_data.expired_mask);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_data.status);
          errors++;
        end
        if (out_data.assigned_id !== exp_res.assigned_id) begin
          $error("assigned_id: expected %0d, got %0d",
                 exp_res.assigned_id, out_data.assigned_id);
          errors++;
        end
        if (out_data.expired_mask !== exp_res.expired_mask) begin
          $error("expired_mask: expected %h, got %h",
                 exp_res.expired_mask, out_data.expired_mask);
          errors++;
        end
      end
    end
    took = rst_n && start && !busy;
    if (took) begin
      exp_res = predict_watchdog(in_data);
      expected_results.push_back(exp_res);
      if (in_data.cmd == CMD_CHECK) n_checks++;
      if (exp_res.status == ST_BUSY) n_timeouts++;
      if (in_data.cmd == CMD_REGISTER) n_registers++;
      if (exp_res.status == ST_FULL) n_full++;
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    logic [31:0] sys_tick;
    logic [31:0] tick;
    logic [7:0]  id;
    int          sel;
    int          slot;
    shadow_init  = 1'b0;
    shadow_count = 0;
    for (int i = 0; i < TASK_SLOTS; i++) shadow_armed[i] = 1'b0;

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: commands before init, init twice, bad ids, tick extremes
    pending_cmds.push_back(make_cmd(CMD_CHECK,    8'd0,   32'd0,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_REGISTER, 8'd0,   32'd5,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_ENABLE,   8'hFF,  32'd0,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_FEED,     8'd3,   32'd0,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_UNUSED,   8'd0,   32'd0,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_INIT,     8'd0,   32'd0,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_INIT,     8'd0,   32'd0,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_CHECK,    8'd0,   32'd0,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_DISABLE,  8'd16,  32'd0,    32'd0));
    // writes to slots not yet registered, later overwritten by register
    pending_cmds.push_back(make_cmd(CMD_PERIOD,   8'd0,   32'd7,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_ENABLE,   8'd1,   32'd0,    32'd5));
    pending_cmds.push_back(make_cmd(CMD_REGISTER, 8'd0,   TICK_ALL, 32'd0));
    pending_cmds.push_back(make_cmd(CMD_REGISTER, 8'd0,   32'd0,    TICK_ALL));
    pending_cmds.push_back(make_cmd(CMD_REGISTER, 8'd0,   32'd10,   32'd100));
    pending_cmds.push_back(make_cmd(CMD_ENABLE,   8'd0,   32'd0,    TICK_ALL));
    pending_cmds.push_back(make_cmd(CMD_ENABLE,   8'd1,   32'd0,    TICK_ALL));
    pending_cmds.push_back(make_cmd(CMD_ENABLE,   8'd2,   32'd0,    32'd100));
    // tick going backwards gives a huge elapsed time
    pending_cmds.push_back(make_cmd(CMD_CHECK,    8'd0,   32'd0,    TICK_ALL));
    // elapsed equal to the period, then one past it
    pending_cmds.push_back(make_cmd(CMD_CHECK,    8'd0,   32'd0,    32'd110));
    pending_cmds.push_back(make_cmd(CMD_CHECK,    8'd0,   32'd0,    32'd111));
    pending_cmds.push_back(make_cmd(CMD_FEED,     8'd1,   32'd0,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_PERIOD,   8'd2,   TICK_ALL, 32'd0));
    pending_cmds.push_back(make_cmd(CMD_DISABLE,  8'd1,   32'd0,    32'd0));
    pending_cmds.push_back(make_cmd(CMD_CHECK,    8'd0,   32'd0,    32'hFFFF_FFFE));
    pending_cmds.push_back(make_cmd(CMD_FEED,     8'd15,  32'd0,    TICK_ALL));

    // Random: three phases of sender idling
    sys_tick = $urandom;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 16 : (phase == 1) ? 77 : 0;
      for (int n = 0; n < 342; n++) begin
        while (pending_cmds.size() >= 2) @(posedge clk);
        sys_tick = sys_tick + $urandom_range(0, 12);
        tick = ($urandom_range(0, 19) == 0) ? $urandom : sys_tick;
        id = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, TASK_SLOTS - 1));
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
          pending_cmds.push_back(make_cmd(CMD_REGISTER, id, pick_period(), tick));
        end else if (sel < 20) begin
          pending_cmds.push_back(make_cmd(CMD_ENABLE, id, $urandom, tick));
        end else if (sel < 28) begin
          pending_cmds.push_back(make_cmd(CMD_DISABLE, id, $urandom, tick));
        end else if (sel < 38) begin
          pending_cmds.push_back(make_cmd(CMD_PERIOD, id, pick_period(), tick));
        end else if (sel < 60) begin
          pending_cmds.push_back(make_cmd(CMD_FEED, id, $urandom, tick));
        end else if (sel < 92) begin
          // aim some checks right at a task's deadline
          if (shadow_count > 0 && $urandom_range(0, 9) < 4) begin
            slot = $urandom_range(0, shadow_count - 1);
            tick = shadow_fed_at[slot] + shadow_period[slot] + $urandom_range(0, 3) - 1;
          end
          pending_cmds.push_back(make_cmd(CMD_CHECK, id, $urandom, tick));
        end else if (sel < 94) begin
          pending_cmds.push_back(make_cmd(CMD_INIT, id, $urandom, tick));
        end else if (sel < 96) begin
          pending_cmds.push_back(make_cmd(CMD_UNUSED, id, $urandom, tick));
        end else begin
          pending_cmds.push_back(make_cmd(3'($urandom_range(CMD_ENABLE, CMD_FEED)),
                                          8'($urandom_range(TASK_SLOTS, 255)),
                                          $urandom, tick));
        end
      end
    end

    // Drain
    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d commands with %0d results: %0d checks, %0d of them with a timeout.",
             n_results, n_results, n_checks, n_timeouts);
    $display("Registrations: %0d, %0d of them refused on a full table.", n_registers, n_full);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
